[rtl/core/pef_pkg.sv]
// Package for the packet entry FIFO: request and result records, entry
// metadata record, opcode and status codes, sequencer states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pef_pkg;

  localparam int LEN_W  = 7;
  localparam int FILL_W = 4;

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_PEEK  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;
  localparam logic [1:0] STAT_TRUNC = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_META,
    S_STREAM
  } pef_state_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_byte;
    logic [7:0] entry_id;
    logic       confirmed_in;
    logic       ack_in;
  } pef_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [7:0]        out_byte;
    logic              out_valid;
    logic [7:0]        out_id;
    logic              out_confirmed;
    logic              out_ack;
    logic [LEN_W-1:0]  out_length;
    logic              last_result;
    logic [FILL_W-1:0] fill_count;
  } pef_out_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [7:0]       id;
    logic             conf;
    logic             ack;
  } pef_meta_t;

endpackage

`default_nettype wire

[rtl/core/pef_channels.sv]
// Valid/ready channel interfaces for the packet entry FIFO requests and results.
// Depends on pef_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface pef_in_if import pef_pkg::*; ();
  logic    valid;
  logic    ready;
  pef_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pef_out_if import pef_pkg::*; ();
  logic     valid;
  logic     ready;
  pef_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/packet_entry_fifo.sv]
// Packet entry FIFO top level: ring queue of DEPTH entries, each a payload of
// up to MAX_PAYLOAD bytes plus id and flags. Depends on pef_pkg, pef_channels,
// pef_store.
//
// Usage:
//  - in_chan carries one request per valid/ready handshake: push byte, pop,
//    peek or clear. out_chan carries result items, same handshake.
//  - Push, clear and any request on an empty queue load one result into the
//    output register when accepted: one request per cycle unless stalled.
//  - Pop/peek of a non-empty entry: the accept reads the metadata memory,
//    then the payload memory streams one byte per cycle unless the receiver
//    stalls (read address runs one ahead of the output register). An entry of
//    L bytes holds the input through accept, metadata read and L bytes; a
//    zero-length entry gives its one result from the metadata read state.
//  - Requests are taken only while the sequencer is idle and the output
//    register is empty or being drained this cycle.
//  - Receiver stall: the output register holds its result, the stream
//    pauses on the pending read data, and in_chan.ready stays low.
//  - Reset (rst_n low, synchronous) empties the queue and aborts any open
//    push; memory contents are left as they are (no clearing pass).
//  - fill_count on every result is the occupancy after the request; a pop
//    already counts its entry as freed.
`timescale 1ns / 1ps
`default_nettype none

module packet_entry_fifo import pef_pkg::*; #(
  parameter int DEPTH       = 8,
  parameter int MAX_PAYLOAD = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  pef_in_if.sink    in_chan,
  pef_out_if.source out_chan
);

  localparam int SLOT_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int OFF_W  = $clog2(MAX_PAYLOAD + 1);
  localparam int ADDR_W = $clog2(DEPTH * MAX_PAYLOAD);

  // sequencer and queue control
  pef_state_t        state_r, state_nxt;
  logic [SLOT_W-1:0] head_r, head_nxt;
  logic [SLOT_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [OFF_W-1:0]  woff_r, woff_nxt;
  logic              open_r, open_nxt;
  logic              drop_r, drop_nxt;
  logic              trunc_r, trunc_nxt;

  // read stream context
  logic [SLOT_W-1:0] hslot_r, hslot_nxt;
  logic [OFF_W-1:0]  idx_r, idx_nxt;
  pef_meta_t         meta_r, meta_nxt;

  // output register
  logic              oval_r, oval_nxt;
  pef_out_t          odata_r, odata_nxt;

  // memory ports
  logic              pl_we, pl_re, meta_we, meta_re;
  logic [ADDR_W-1:0] pl_waddr, pl_raddr;
  logic [7:0]        pl_rdata;
  logic [SLOT_W-1:0] meta_waddr, meta_raddr;
  pef_meta_t         meta_wdata, meta_rdata, meta_cl;

  // push working values
  logic              cur_drop, cur_trunc, do_store;
  logic [OFF_W-1:0]  cur_off;
  logic              out_free, take_req, stream_last;
  logic [ADDR_W-1:0] head_base;
  pef_in_t           req;

  assign req      = in_chan.data;
  assign out_free = !oval_r || out_chan.ready;
  assign in_chan.ready  = (state_r == S_IDLE) && out_free;
  assign take_req       = in_chan.ready && in_chan.valid;
  assign out_chan.valid = oval_r;
  assign out_chan.data  = odata_r;

  assign head_base   = ADDR_W'(hslot_r) * ADDR_W'(MAX_PAYLOAD);
  assign stream_last = (LEN_W'(idx_r) + LEN_W'(1)) == meta_r.len;

  // stored length never exceeds MAX_PAYLOAD; clamp keeps the stream bounded
  always_comb begin
    meta_cl = meta_rdata;
    if (meta_rdata.len > LEN_W'(MAX_PAYLOAD)) begin
      meta_cl.len = LEN_W'(MAX_PAYLOAD);
    end
  end

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    woff_nxt  = woff_r;
    open_nxt  = open_r;
    drop_nxt  = drop_r;
    trunc_nxt = trunc_r;
    hslot_nxt = hslot_r;
    idx_nxt   = idx_r;
    meta_nxt  = meta_r;
    oval_nxt  = oval_r && !out_chan.ready;
    odata_nxt = odata_r;

    pl_we      = 1'b0;
    pl_waddr   = '0;
    pl_re      = 1'b0;
    pl_raddr   = '0;
    meta_we    = 1'b0;
    meta_waddr = tail_r;
    meta_wdata = '0;
    meta_re    = 1'b0;
    meta_raddr = head_r;

    // a push opens an entry on its first item; full queue drops the entry
    cur_drop  = open_r ? drop_r : (count_r >= CNT_W'(DEPTH));
    cur_trunc = open_r ? trunc_r : 1'b0;
    cur_off   = open_r ? woff_r : '0;
    do_store  = !cur_drop && req.byte_valid && (cur_off < OFF_W'(MAX_PAYLOAD));

    unique case (state_r)
      S_IDLE: begin
        if (take_req) begin
          oval_nxt  = 1'b1;
          odata_nxt = '0;
          odata_nxt.last_result = 1'b1;
          unique case (req.opcode)
            OP_PUSH: begin
              if (!cur_drop && req.byte_valid && !do_store) begin
                cur_trunc = 1'b1;
              end
              pl_we    = do_store;
              pl_waddr = ADDR_W'(tail_r) * ADDR_W'(MAX_PAYLOAD) + ADDR_W'(cur_off);
              if (do_store) begin
                cur_off = cur_off + OFF_W'(1);
              end
              odata_nxt.status = cur_drop ? STAT_FULL : (cur_trunc ? STAT_TRUNC : STAT_OK);
              if (req.last_byte) begin
                if (!cur_drop) begin
                  meta_we         = 1'b1;
                  meta_wdata.len  = LEN_W'(cur_off);
                  meta_wdata.id   = req.entry_id;
                  meta_wdata.conf = req.confirmed_in;
                  meta_wdata.ack  = req.ack_in;
                  tail_nxt  = (tail_r == SLOT_W'(DEPTH - 1)) ? '0 : tail_r + SLOT_W'(1);
                  count_nxt = count_r + CNT_W'(1);
                end
                open_nxt  = 1'b0;
                drop_nxt  = 1'b0;
                trunc_nxt = 1'b0;
                woff_nxt  = '0;
              end else begin
                open_nxt  = 1'b1;
                drop_nxt  = cur_drop;
                trunc_nxt = cur_trunc;
                woff_nxt  = cur_off;
              end
            end
            OP_POP, OP_PEEK: begin
              if (count_r == '0) begin
                odata_nxt.status = STAT_EMPTY;
              end else begin
                // metadata read now, result comes from the stream states
                oval_nxt  = 1'b0;
                meta_re   = 1'b1;
                hslot_nxt = head_r;
                state_nxt = S_META;
                if (req.opcode == OP_POP) begin
                  head_nxt  = (head_r == SLOT_W'(DEPTH - 1)) ? '0 : head_r + SLOT_W'(1);
                  count_nxt = count_r - CNT_W'(1);
                end
              end
            end
            OP_CLEAR: begin
              head_nxt  = '0;
              tail_nxt  = '0;
              count_nxt = '0;
              woff_nxt  = '0;
              open_nxt  = 1'b0;
              drop_nxt  = 1'b0;
              trunc_nxt = 1'b0;
            end
            default: ;
          endcase
          odata_nxt.fill_count = FILL_W'(count_nxt);
        end
      end

      S_META: begin
        meta_nxt = meta_cl;
        if (meta_cl.len == '0) begin
          if (out_free) begin
            oval_nxt  = 1'b1;
            odata_nxt = '0;
            odata_nxt.out_id        = meta_cl.id;
            odata_nxt.out_confirmed = meta_cl.conf;
            odata_nxt.out_ack       = meta_cl.ack;
            odata_nxt.last_result   = 1'b1;
            odata_nxt.fill_count    = FILL_W'(count_r);
            state_nxt = S_IDLE;
          end
        end else begin
          pl_re     = 1'b1;
          pl_raddr  = head_base;
          idx_nxt   = '0;
          state_nxt = S_STREAM;
        end
      end

      S_STREAM: begin
        // pl_rdata holds byte idx_r until the output register takes it
        if (out_free) begin
          oval_nxt  = 1'b1;
          odata_nxt.status        = STAT_OK;
          odata_nxt.out_byte      = pl_rdata;
          odata_nxt.out_valid     = 1'b1;
          odata_nxt.out_id        = meta_r.id;
          odata_nxt.out_confirmed = meta_r.conf;
          odata_nxt.out_ack       = meta_r.ack;
          odata_nxt.out_length    = meta_r.len;
          odata_nxt.last_result   = stream_last;
          odata_nxt.fill_count    = FILL_W'(count_r);
          if (stream_last) begin
            state_nxt = S_IDLE;
          end else begin
            pl_re    = 1'b1;
            idx_nxt  = idx_r + OFF_W'(1);
            pl_raddr = head_base + ADDR_W'(idx_nxt);
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      woff_r  <= '0;
      open_r  <= 1'b0;
      drop_r  <= 1'b0;
      trunc_r <= 1'b0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      woff_r  <= woff_nxt;
      open_r  <= open_nxt;
      drop_r  <= drop_nxt;
      trunc_r <= trunc_nxt;
      oval_r  <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hslot_r <= hslot_nxt;
    idx_r   <= idx_nxt;
    meta_r  <= meta_nxt;
    odata_r <= odata_nxt;
  end

  pef_store #(
    .DEPTH       (DEPTH),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_store (
    .clk        (clk),
    .pl_we      (pl_we),
    .pl_waddr   (pl_waddr),
    .pl_wdata   (req.data_byte),
    .pl_re      (pl_re),
    .pl_raddr   (pl_raddr),
    .pl_rdata   (pl_rdata),
    .meta_we    (meta_we),
    .meta_waddr (meta_waddr),
    .meta_wdata (meta_wdata),
    .meta_re    (meta_re),
    .meta_raddr (meta_raddr),
    .meta_rdata (meta_rdata)
  );

endmodule

`default_nettype wire

[rtl/core/pef_store.sv]
// Entry storage: payload byte memory and per-slot metadata memory,
// both with one write port and one registered read port. Depends on pef_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pef_store import pef_pkg::*; #(
  parameter int DEPTH       = 8,
  parameter int MAX_PAYLOAD = 64
) (
  input  logic                                 clk,
  input  logic                                 pl_we,
  input  logic [$clog2(DEPTH*MAX_PAYLOAD)-1:0] pl_waddr,
  input  logic [7:0]                           pl_wdata,
  input  logic                                 pl_re,
  input  logic [$clog2(DEPTH*MAX_PAYLOAD)-1:0] pl_raddr,
  output logic [7:0]                           pl_rdata,
  input  logic                                 meta_we,
  input  logic [$clog2(DEPTH)-1:0]             meta_waddr,
  input  pef_meta_t                            meta_wdata,
  input  logic                                 meta_re,
  input  logic [$clog2(DEPTH)-1:0]             meta_raddr,
  output pef_meta_t                            meta_rdata
);

  localparam int PL_DEPTH = DEPTH * MAX_PAYLOAD;

  logic [7:0] pl_mem   [PL_DEPTH];
  pef_meta_t  meta_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (pl_we) begin
      pl_mem[pl_waddr] <= pl_wdata;
    end
    if (pl_re) begin
      pl_rdata <= pl_mem[pl_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    if (meta_re) begin
      meta_rdata <= meta_mem[meta_raddr];
    end
  end

endmodule

`default_nettype wire
